/* rtl/ictf_pkg.sv */
package ictf_pkg;

	// Vector width of the rotation cells and angle width.
	localparam int VecW = 35;
	localparam int AngW = 32;
	localparam int TabFrac = 24;

	// atan(2^-i) in degrees with 24 fraction bits.
	localparam logic [31:0] ATAN_TAB [24] = '{
		32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
		32'd30029717, 32'd15018523, 32'd7509720, 32'd3754917, 32'd1877466,
		32'd938734, 32'd469367, 32'd234684, 32'd117342, 32'd58671, 32'd29335,
		32'd14668, 32'd7334, 32'd3667, 32'd1833, 32'd917, 32'd458, 32'd229, 32'd115
	};

	// One vector travelling down the row of rotation cells.
	typedef struct packed {
		logic                   vld;
		logic                   nz;
		logic signed [VecW-1:0] x;
		logic signed [VecW-1:0] y;
		logic signed [AngW-1:0] z;
	} ictf_vec_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SQ, ST_ROOT, ST_CORDIC, ST_MUL, ST_SUM, ST_DONE
	} ictf_state_t;

	// Register indexes.
	localparam logic [2:0] REG_AX_OFF = 3'd0;
	localparam logic [2:0] REG_AY_OFF = 3'd1;
	localparam logic [2:0] REG_AZ_OFF = 3'd2;
	localparam logic [2:0] REG_GX_OFF = 3'd3;
	localparam logic [2:0] REG_GY_OFF = 3'd4;
	localparam logic [2:0] REG_GZ_OFF = 3'd5;
	localparam logic [2:0] REG_STEP   = 3'd6;
	localparam logic [2:0] REG_GAIN   = 3'd7;

	// Table angle rounded half up to the given number of fraction bits.
	function automatic logic [31:0] atan_q(input int i, input int f);
		logic [31:0] t;
		t = ATAN_TAB[i];
		if (f >= TabFrac) begin
			return t;
		end
		return (t + (32'd1 << (TabFrac - 1 - f))) >> (TabFrac - f);
	endfunction

endpackage

/* rtl/imu_complementary_tilt_filter.sv */
// IMU complementary tilt filter.
// Input channel: one 6-axis sample (accel and gyro words) per request, taken
// on in_valid and in_ready. Output channel: fused pitch, roll and integrated
// yaw in signed degrees with ANGLE_FRAC_BITS fraction bits, on out_valid and
// out_ready. Configuration registers are written through cfg_we, cfg_index
// and cfg_data; the user must write them only while the block is idle, which
// the block itself does not enforce. One sample at a time: offsets are
// removed as the request is taken, then the sample is squared, passed
// through the bit-serial square root and the row of rotation cells, then
// blended and loaded into the output register.
// A new request is taken once the previous sample has reached the output
// register, so a result may wait there while the next sample is computed.
// If the receiver stalls, the finished sample waits in the blend stage and
// accumulators are not disturbed.
// Reset clears the angle accumulators to zero and loads the register
// defaults; no result is pending afterwards.
module imu_complementary_tilt_filter
	import ictf_pkg::*;
#(
	parameter int CORDIC_STEPS    = 16,
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] accel_x_raw,
	input  logic signed [15:0] accel_y_raw,
	input  logic signed [15:0] accel_z_raw,
	input  logic signed [15:0] gyro_x_raw,
	input  logic signed [15:0] gyro_y_raw,
	input  logic signed [15:0] gyro_z_raw,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pitch_angle,
	output logic signed [31:0] roll_angle,
	output logic signed [31:0] yaw_angle,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data
);

	localparam int GyroSh = 32 - ANGLE_FRAC_BITS;

	ictf_state_t state_q, state_d;

	logic signed [15:0] ax_off_q, ay_off_q, gx_off_q, gy_off_q, gz_off_q;
	logic signed [16:0] az_off_q;
	logic [23:0] step_q;
	logic [16:0] gain_q;

	logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q;
	logic signed [40:0] dp_prod_q, dr_prod_q, dy_prod_q;
	logic signed [31:0] p_q, r_q;
	logic signed [31:0] pitch_acc_q, roll_acc_q, yaw_acc_q;
	logic signed [31:0] apitch_q, aroll_q;
	logic signed [49:0] mp1_q, mp2_q, mr1_q, mr2_q;
	logic signed [31:0] pitch_out_q, roll_out_q, yaw_out_q;
	logic               out_valid_q;

	logic accept;
	logic load_out;
	logic launch;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_off_q <= '0;
			ay_off_q <= '0;
			az_off_q <= '0;
			gx_off_q <= '0;
			gy_off_q <= '0;
			gz_off_q <= '0;
			step_q   <= 24'd2001;
			gain_q   <= 17'd64225;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AX_OFF: ax_off_q <= cfg_data[15:0];
				REG_AY_OFF: ay_off_q <= cfg_data[15:0];
				REG_AZ_OFF: az_off_q <= cfg_data[16:0];
				REG_GX_OFF: gx_off_q <= cfg_data[15:0];
				REG_GY_OFF: gy_off_q <= cfg_data[15:0];
				REG_GZ_OFF: gz_off_q <= cfg_data[15:0];
				REG_STEP:   step_q   <= cfg_data;
				REG_GAIN:   gain_q   <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Offset removal, wrapping to 16 bits.
	always_ff @(posedge clk) begin
		if (accept) begin
			ax_q <= accel_x_raw - ax_off_q;
			ay_q <= accel_y_raw - ay_off_q;
			az_q <= 16'(accel_z_raw - az_off_q[15:0]);
			gx_q <= gyro_x_raw - gx_off_q;
			gy_q <= gyro_y_raw - gy_off_q;
			gz_q <= gyro_z_raw - gz_off_q;
		end
	end

	// Squared leg lengths for the two accel angles.
	logic [31:0] pitch_sq, roll_sq;
	logic signed [31:0] sqx, sqy, sqz;
	always_comb begin
		sqx = ax_q * ax_q;
		sqy = ay_q * ay_q;
		sqz = az_q * az_q;
		pitch_sq = unsigned'(sqy) + unsigned'(sqz);
		roll_sq  = unsigned'(sqx) + unsigned'(sqz);
	end

	logic [31:0] pitch_root, roll_root;
	logic        pitch_done, roll_done;

	ictf_sqrt u_sqrt_pitch (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_SQ),
		.sq     (pitch_sq),
		.root   (pitch_root),
		.done   (pitch_done)
	);

	ictf_sqrt u_sqrt_roll (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_SQ),
		.sq     (roll_sq),
		.root   (roll_root),
		.done   (roll_done)
	);

	// Gyro rate times step factor.
	always_ff @(posedge clk) begin
		if (state_q == ST_SQ) begin
			dp_prod_q <= gy_q * signed'({1'b0, step_q});
			dr_prod_q <= gx_q * signed'({1'b0, step_q});
			dy_prod_q <= gz_q * signed'({1'b0, step_q});
		end
	end

	// Rounded gyro steps and saturating integration.
	logic signed [41:0] dp_rnd, dr_rnd, dy_rnd;
	logic signed [42:0] p_sum, r_sum;
	always_comb begin
		dp_rnd = (42'(dp_prod_q) + (42'sd1 <<< (GyroSh - 1))) >>> GyroSh;
		dr_rnd = (42'(dr_prod_q) + (42'sd1 <<< (GyroSh - 1))) >>> GyroSh;
		dy_rnd = (42'(dy_prod_q) + (42'sd1 <<< (GyroSh - 1))) >>> GyroSh;
		p_sum  = 43'(pitch_acc_q) + 43'(dp_rnd);
		r_sum  = 43'(roll_acc_q) + 43'(dr_rnd);
	end

	function automatic logic signed [31:0] sat_43(input logic signed [42:0] v);
		if (v > 43'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end
		if (v < -43'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	always_ff @(posedge clk) begin
		if (state_q == ST_ROOT) begin
			p_q <= sat_43(p_sum);
			r_q <= sat_43(r_sum);
		end
	end

	// Row of rotation cells, one vector each for pitch and roll.
	assign launch = (state_q == ST_ROOT) && pitch_done && roll_done;

	ictf_vec_t pv [CORDIC_STEPS+1];
	ictf_vec_t rv [CORDIC_STEPS+1];

	always_comb begin
		pv[0].vld = launch;
		pv[0].nz  = (ax_q != '0);
		pv[0].x   = signed'(VecW'(pitch_root));
		pv[0].y   = VecW'(ax_q) <<< 16;
		pv[0].z   = '0;
		rv[0].vld = launch;
		rv[0].nz  = (ay_q != '0);
		rv[0].x   = signed'(VecW'(roll_root));
		rv[0].y   = VecW'(ay_q) <<< 16;
		rv[0].z   = '0;
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_row
		ictf_cell #(
			.SHIFT (i),
			.ANGLE (atan_q(i, ANGLE_FRAC_BITS))
		) u_cell_pitch (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (pv[i]),
			.dout   (pv[i+1])
		);
		ictf_cell #(
			.SHIFT (i),
			.ANGLE (atan_q(i, ANGLE_FRAC_BITS))
		) u_cell_roll (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (rv[i]),
			.dout   (rv[i+1])
		);
	end

	// Accel angles at the end of the row; roll is negated.
	always_ff @(posedge clk) begin
		if (state_q == ST_CORDIC && pv[CORDIC_STEPS].vld) begin
			apitch_q <= pv[CORDIC_STEPS].nz ? pv[CORDIC_STEPS].z : '0;
			aroll_q  <= rv[CORDIC_STEPS].nz ? -rv[CORDIC_STEPS].z : '0;
		end
	end

	// Blend products.
	logic signed [17:0] g_s, ng_s;
	always_comb begin
		g_s  = (gain_q > 17'd65536) ? 18'sd65536 : signed'({1'b0, gain_q});
		ng_s = 18'sd65536 - g_s;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			mp1_q <= g_s * p_q;
			mp2_q <= ng_s * apitch_q;
			mr1_q <= g_s * r_q;
			mr2_q <= ng_s * aroll_q;
		end
	end

	logic signed [50:0] bp_sum, br_sum;
	logic signed [42:0] bp_sh, br_sh;
	always_comb begin
		bp_sum = 51'(mp1_q) + 51'(mp2_q) + 51'sd32768;
		br_sum = 51'(mr1_q) + 51'(mr2_q) + 51'sd32768;
		bp_sh  = 43'(bp_sum >>> 16);
		br_sh  = 43'(br_sum >>> 16);
	end

	// Angle accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_acc_q <= '0;
			roll_acc_q  <= '0;
			yaw_acc_q   <= '0;
		end else if (state_q == ST_SUM) begin
			pitch_acc_q <= sat_43(bp_sh);
			roll_acc_q  <= sat_43(br_sh);
			yaw_acc_q   <= yaw_acc_q + dy_rnd[31:0];
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE:   if (accept) state_d = ST_SQ;
			ST_SQ:     state_d = ST_ROOT;
			ST_ROOT:   if (launch) state_d = ST_CORDIC;
			ST_CORDIC: if (pv[CORDIC_STEPS].vld) state_d = ST_MUL;
			ST_MUL:    state_d = ST_SUM;
			ST_SUM:    state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pitch_out_q <= pitch_acc_q;
			roll_out_q  <= roll_acc_q;
			yaw_out_q   <= yaw_acc_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign pitch_angle = pitch_out_q;
	assign roll_angle  = roll_out_q;
	assign yaw_angle   = yaw_out_q;

endmodule

/* rtl/ictf_sqrt.sv */
module ictf_sqrt
	import ictf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] sq,
	output logic [31:0] root,
	output logic        done
);

	logic [63:0] n_q;
	logic [35:0] rem_q;
	logic [31:0] res_q;
	logic [5:0]  cnt_q;
	logic [35:0] rem_sh;
	logic [35:0] trial;

	// Two radicand bits enter the partial remainder per cycle.
	assign rem_sh = {rem_q[33:0], n_q[63:62]};
	assign trial  = {2'b00, res_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	// Restoring square root, one result bit per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= {sq, 32'd0};
			rem_q <= '0;
			res_q <= '0;
		end else if (cnt_q != '0) begin
			n_q <= {n_q[61:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q <= rem_sh - trial;
				res_q <= {res_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				res_q <= {res_q[30:0], 1'b0};
			end
		end
	end

	assign root = res_q;
	assign done = (cnt_q == '0);

endmodule

/* rtl/ictf_cell.sv */
module ictf_cell
	import ictf_pkg::*;
#(
	parameter int          SHIFT = 0,
	parameter logic [31:0] ANGLE = 32'd0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ictf_vec_t din,
	output ictf_vec_t dout
);

	logic signed [VecW-1:0] xs;
	logic signed [VecW-1:0] ys;
	ictf_vec_t nxt;
	logic      vld_q;
	ictf_vec_t dat_q;

	// One vectoring step: rotate toward the x axis by a fixed angle.
	always_comb begin
		xs = din.x >>> SHIFT;
		ys = din.y >>> SHIFT;
		nxt = din;
		if (!din.y[VecW-1]) begin
			nxt.x = din.x + ys;
			nxt.y = din.y - xs;
			nxt.z = din.z + signed'(ANGLE);
		end else begin
			nxt.x = din.x - ys;
			nxt.y = din.y + xs;
			nxt.z = din.z - signed'(ANGLE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		dat_q <= nxt;
	end

	// The valid bit comes from the reset register, the vector from the data register.
	always_comb begin
		dout     = dat_q;
		dout.vld = vld_q;
	end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
	import ictf_pkg::*;

	localparam int Steps   = 16;
	localparam int Frac    = 16;
	localparam int Limit   = 1000000;
	localparam int Settle  = 100;

	typedef struct {
		logic signed [15:0] ax, ay, az, gx, gy, gz;
	} imu_sample_t;

	typedef struct {
		logic signed [31:0] pitch, roll, yaw;
	} tilt_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [15:0] accel_x_raw = 0, accel_y_raw = 0, accel_z_raw = 0;
	logic signed [15:0] gyro_x_raw = 0, gyro_y_raw = 0, gyro_z_raw = 0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [31:0] pitch_angle, roll_angle, yaw_angle;
	logic cfg_we = 0;
	logic [2:0] cfg_index = REG_AX_OFF;
	logic [23:0] cfg_data = 0;

	imu_complementary_tilt_filter DUT (.*);

	// Predictor state: register copies and angle accumulators.
	longint offs [6];
	longint step_factor;
	longint gain;
	logic signed [31:0] pitch_st, roll_st;
	logic [31:0] yaw_st;

	imu_sample_t pending_q[$];
	tilt_t angle_q[$];
	imu_sample_t cur;
	int fails = 0;
	int cycle = 0;
	bit calm = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	// Floor square root of a 64-bit value.
	function automatic longint unsigned root64(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Vectoring rotation: angle of (adjacent, opposite) in degrees.
	function automatic longint tilt_angle(longint opp, longint unsigned adj_sq);
		longint x, y, z, xs, ys, ai;
		x = longint'(root64(adj_sq << 32));
		y = opp * 65536;
		z = 0;
		if (y == 0) return 0;
		for (int i = 0; i < Steps; i++) begin
			ai = (longint'(ATAN_TAB[i]) + (longint'(1) << (TabFrac - Frac - 1)))
				>>> (TabFrac - Frac);
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys; y = y - xs; z = z + ai;
			end else begin
				x = x - ys; y = y + xs; z = z - ai;
			end
		end
		return z;
	endfunction

	function automatic longint strip(logic [15:0] raw, longint off);
		logic [15:0] d;
		d = raw - off[15:0];
		return longint'($signed(d));
	endfunction

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint gyro_delta(longint rate);
		return (rate * step_factor + 32768) >>> (32 - Frac);
	endfunction

	function automatic longint mix(longint acc, longint ang, longint g);
		return clip32((g * acc + (65536 - g) * ang + 32768) >>> 16);
	endfunction

	// Advance the accumulators by one sample and return the fused angles.
	function automatic tilt_t fuse(imu_sample_t s);
		longint ax, ay, az, gx, gy, gz, ap, ar, g, p, r;
		tilt_t t;
		ax = strip(s.ax, offs[0]); ay = strip(s.ay, offs[1]); az = strip(s.az, offs[2]);
		gx = strip(s.gx, offs[3]); gy = strip(s.gy, offs[4]); gz = strip(s.gz, offs[5]);
		ap = tilt_angle(ax, longint'(ay * ay + az * az));
		ar = -tilt_angle(ay, longint'(ax * ax + az * az));
		g = (gain > 65536) ? 65536 : gain;
		p = clip32(longint'(pitch_st) + gyro_delta(gy));
		r = clip32(longint'(roll_st) + gyro_delta(gx));
		yaw_st = yaw_st + 32'(gyro_delta(gz));
		pitch_st = 32'(mix(p, ap, g));
		roll_st = 32'(mix(r, ar, g));
		t.pitch = pitch_st;
		t.roll = roll_st;
		t.yaw = yaw_st;
		return t;
	endfunction

	// Driver: presents queued samples, predicts each accepted request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
		end else begin
			if (in_valid && in_ready) angle_q.push_back(fuse(cur));
			if (!in_valid || in_ready) begin
				if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 23)) begin
					cur = pending_q.pop_front();
					accel_x_raw <= cur.ax; accel_y_raw <= cur.ay; accel_z_raw <= cur.az;
					gyro_x_raw <= cur.gx; gyro_y_raw <= cur.gy; gyro_z_raw <= cur.gz;
					in_valid <= 1;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// Monitor: random backpressure and field checks against the oldest prediction.
	always @(posedge clk) begin
		tilt_t e;
		cycle <= cycle + 1;
		out_ready <= calm || ($urandom_range(99) >= 23);
		if (arst_n && out_valid && out_ready) begin
			if (angle_q.size() == 0) begin
				$error("unexpected result pitch=%0d roll=%0d yaw=%0d",
					pitch_angle, roll_angle, yaw_angle);
				fails++;
			end else begin
				e = angle_q.pop_front();
				if (pitch_angle !== e.pitch) begin
					$error("pitch_angle expected %0d actual %0d", e.pitch, pitch_angle);
					fails++;
				end
				if (roll_angle !== e.roll) begin
					$error("roll_angle expected %0d actual %0d", e.roll, roll_angle);
					fails++;
				end
				if (yaw_angle !== e.yaw) begin
					$error("yaw_angle expected %0d actual %0d", e.yaw, yaw_angle);
					fails++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		if (cycle == Limit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, longint val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val[23:0];
		@(posedge clk);
		cfg_we <= 0;
		if (idx <= REG_GZ_OFF) begin
			offs[idx] = (idx == REG_AZ_OFF) ? longint'($signed(val[16:0]))
				: longint'($signed(val[15:0]));
		end else if (idx == REG_STEP) begin
			step_factor = longint'(val[23:0]);
		end else begin
			gain = longint'(val[16:0]);
		end
	endtask

	task automatic write_all(longint ax, longint ay, longint az, longint gx, longint gy,
			longint gz, longint st, longint g);
		write_reg(REG_AX_OFF, ax); write_reg(REG_AY_OFF, ay); write_reg(REG_AZ_OFF, az);
		write_reg(REG_GX_OFF, gx); write_reg(REG_GY_OFF, gy); write_reg(REG_GZ_OFF, gz);
		write_reg(REG_STEP, st); write_reg(REG_GAIN, g);
	endtask

	function automatic imu_sample_t make_sample(int ax, int ay, int az, int gx, int gy,
			int gz);
		imu_sample_t s;
		s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
		s.gx = 16'(gx); s.gy = 16'(gy); s.gz = 16'(gz);
		return s;
	endfunction

	function automatic logic [15:0] corner_word();
		case ($urandom_range(3))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			default: return 16'(int'($urandom_range(8)) - 4);
		endcase
	endfunction

	// Mostly plausible motion, with some full-range and corner samples.
	function automatic imu_sample_t rand_sample();
		imu_sample_t s;
		int kind;
		kind = $urandom_range(99);
		if (kind < 65) begin
			s = make_sample(int'($urandom_range(16000)) - 8000,
				int'($urandom_range(16000)) - 8000,
				int'($urandom_range(8000)) + 12000,
				int'($urandom_range(2000)) - 1000, int'($urandom_range(2000)) - 1000,
				int'($urandom_range(2000)) - 1000);
		end else if (kind < 88) begin
			s.ax = 16'($urandom); s.ay = 16'($urandom); s.az = 16'($urandom);
			s.gx = 16'($urandom); s.gy = 16'($urandom); s.gz = 16'($urandom);
		end else begin
			s.ax = corner_word(); s.ay = corner_word(); s.az = corner_word();
			s.gx = corner_word(); s.gy = corner_word(); s.gz = corner_word();
		end
		return s;
	endfunction

	task automatic drain();
		while (pending_q.size() > 0 || angle_q.size() > 0 || in_valid) @(posedge clk);
		repeat (Settle) @(posedge clk);
	endtask

	task automatic run_random(int n);
		repeat (n) pending_q.push_back(rand_sample());
		drain();
	endtask

	initial begin
		offs = '{0, 0, 0, 0, 0, 0};
		step_factor = 2001;
		gain = 64225;
		pitch_st = 0;
		roll_st = 0;
		yaw_st = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;

		// Directed samples under the reset register values.
		pending_q.push_back(make_sample(0, 0, 0, 0, 0, 0));
		pending_q.push_back(make_sample(0, 0, 16384, 0, 0, 0));
		pending_q.push_back(make_sample(16384, 0, 0, 100, -100, 50));
		pending_q.push_back(make_sample(0, 16384, 0, -100, 100, -50));
		pending_q.push_back(make_sample(-32768, -32768, -32768, -32768, -32768, -32768));
		pending_q.push_back(make_sample(32767, 32767, 32767, 32767, 32767, 32767));
		pending_q.push_back(make_sample(32767, -32768, 0, 0, 32767, -32768));
		pending_q.push_back(make_sample(-32768, 0, 32767, 1, -1, 0));
		pending_q.push_back(make_sample(0, -32768, -32768, 0, 0, 32767));
		pending_q.push_back(make_sample(1, 0, 0, 0, 0, 0));
		pending_q.push_back(make_sample(0, -1, 0, 0, 0, 0));
		pending_q.push_back(make_sample(5000, 5000, 5000, 0, 0, 0));
		drain();

		// Saturation: largest step, gain above one, maximum offsets; no idling.
		calm = 1;
		write_all(32767, 32767, 65535, 32767, 32767, 32767, 24'hffffff, 131071);
		repeat (8) pending_q.push_back(make_sample(-32768, -32768, -32768, -32768,
			-32768, -32768));
		repeat (8) pending_q.push_back(make_sample(32767, 32767, 32767, 32767, 32767,
			32767));
		run_random(170);
		calm = 0;

		// Minimum offsets, zero step, accel only.
		write_all(-32768, -32768, -65536, -32768, -32768, -32768, 0, 0);
		run_random(180);

		// Typical calibration, full gyro trust.
		write_all(120, -80, 16384, 15, -20, 7, 4000, 65536);
		run_random(170);

		// Default-like gain with moderate step.
		write_all(0, 0, 0, 0, 0, 0, 2001, 64225);
		run_random(170);

		// Random register values.
		write_all(int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768,
			int'($urandom_range(131071)) - 65536, int'($urandom_range(65535)) - 32768,
			int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768,
			$urandom_range(24'hffffff), $urandom_range(131071));
		run_random(180);

		if (fails == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/ictf_pkg.sv
rtl/ictf_sqrt.sv
rtl/ictf_cell.sv
rtl/imu_complementary_tilt_filter.sv
test/tb.sv
